// ----- rtl/btbf_pkg.sv -----
`default_nettype none
package btbf_pkg;
  localparam int NumBlocks     = 16;
  localparam int LinesPerBlock = 4096;
  localparam int BlockBytesMax = 256;
  localparam int HashCount     = 4;

  localparam int BlkW    = $clog2(NumBlocks);
  localparam int OffW    = $clog2(BlockBytesMax);
  localparam int AddrW   = BlkW + OffW;
  localparam int MemDepth = NumBlocks * BlockBytesMax;
  localparam int KW      = $clog2(HashCount + 1);
  localparam int LineBlkW = 16 - $clog2(LinesPerBlock) + 1;

  localparam logic [63:0] FnvBasis = 64'hcbf29ce484222325;
  localparam logic [63:0] FnvPrime = 64'h00000100000001b3;

  localparam logic [3:0] LgMax = 4'd12;
  localparam logic [AddrW-1:0] ClrLast = AddrW'(MemDepth - 1);

  localparam logic [0:0] RegEnable = 1'd0;
  localparam logic [0:0] RegLog2   = 1'd1;

  typedef enum logic [2:0] {
    StClear, StIdle, StHash, StProbe, StRead, StResult
  } state_e;

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) r = c + 8'd32;
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/blocked_trigram_bloom_filter_unit.sv -----
// Trigram Bloom filter over NUM_BLOCKS blocks, one text byte per request.
// After reset a clearing pass zeroes all 4096 bytes of the bit memory; in_ready_o
// stays low meanwhile. in_ready_o is high only in the idle state, so requests are
// taken one at a time. A byte that forms no probed trigram passes through accept,
// hash check and finish. A trigram probe goes through accept, the hash, the probes
// and finish: the FNV-1a hash folds in one byte a cycle, with the prime multiply
// done as shifts and adds, then each of the HASH_COUNT probes reads the single-port
// bit memory and then sets or tests the bit.
// A query result waits in an output register until taken; a later query's last
// byte holds in its final cycle while that register is still full.
`default_nettype none
module blocked_trigram_bloom_filter_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:2]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        mode_i,
  input  wire logic [15:0] line_index_i,
  input  wire logic [7:0]  text_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             match_o
);
  localparam int AW = btbf_pkg::AddrW;

  logic en_q;
  logic [3:0] lg_q;
  btbf_pkg::state_e st_q, st_d;
  logic [AW-1:0] clr_q;
  logic [7:0] p1_q, p2_q, c_q;
  logic [1:0] seen_q;
  logic ms_q, ms_d;
  logic mode_q, last_q, inr_q;
  logic [btbf_pkg::BlkW-1:0] blk_q;
  logic [btbf_pkg::NumBlocks-1:0] wr_q;
  logic [63:0] h_q;
  logic [1:0] hstep_q;
  logic [btbf_pkg::KW-1:0] k_q;
  logic [31:0] comb_q;
  logic ov_q, ov_d, m_q;
  logic [7:0] mem [btbf_pkg::MemDepth];
  logic [7:0] rd_q;
  logic [AW-1:0] addr_q;
  logic [7:0] bm_q;

  logic acc;
  logic [7:0] lc;
  logic [btbf_pkg::LineBlkW-1:0] lblk;
  logic written, probe;
  logic [3:0] lg;
  logic [31:0] mask, bitpos;
  logic [7:0] hb;
  logic [63:0] hx, hmul;
  logic res_hold, res_go;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == btbf_pkg::RegLog2) ? {28'd0, lg_q} : {31'd0, en_q};
  assign in_ready_o = (st_q == btbf_pkg::StIdle);
  assign acc = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign match_o = m_q;
  assign lc = btbf_pkg::lower_ascii(text_byte_i);
  assign lblk = btbf_pkg::LineBlkW'(line_index_i / btbf_pkg::LinesPerBlock);
  assign written = inr_q && wr_q[blk_q];
  assign probe = en_q && (seen_q == 2'd2) && (mode_q ? written : inr_q);
  assign lg = (lg_q > btbf_pkg::LgMax) ? btbf_pkg::LgMax : lg_q;
  assign mask = ({28'd0, 4'd8} << lg) - 32'd1;
  assign bitpos = comb_q & mask;
  // a query's last byte waits here while the previous result is still held
  assign res_hold = (st_q == btbf_pkg::StResult) && mode_q && last_q && ov_q &&
                    !out_ready_i;
  assign res_go = (st_q == btbf_pkg::StResult) && !res_hold;
  always_comb begin
    unique case (hstep_q)
      2'd0: hb = p2_q;
      2'd1: hb = p1_q;
      default: hb = c_q;
    endcase
  end
  // prime is 2^40 + 0x1b3
  assign hx = h_q ^ {56'd0, hb};
  assign hmul = hx + (hx << 1) + (hx << 4) + (hx << 5) + (hx << 7) + (hx << 8) +
                (hx << 40);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      btbf_pkg::StClear: if (clr_q == btbf_pkg::ClrLast) st_d = btbf_pkg::StIdle;
      btbf_pkg::StIdle: if (acc) st_d = btbf_pkg::StHash;
      btbf_pkg::StHash: begin
        if (!probe) st_d = btbf_pkg::StResult;
        else if (hstep_q == 2'd2) st_d = btbf_pkg::StProbe;
      end
      btbf_pkg::StProbe: st_d = btbf_pkg::StRead;
      btbf_pkg::StRead: st_d = (k_q == btbf_pkg::KW'(btbf_pkg::HashCount - 1)) ?
                              btbf_pkg::StResult : btbf_pkg::StProbe;
      btbf_pkg::StResult: if (!res_hold) st_d = btbf_pkg::StIdle;
      default: st_d = btbf_pkg::StIdle;
    endcase
  end

  always_comb begin
    ms_d = ms_q;
    if (st_q == btbf_pkg::StRead && mode_q && (rd_q & bm_q) == 8'd0) ms_d = 1'b0;
    if (res_go && last_q) ms_d = 1'b1;
  end

  always_comb begin
    ov_d = ov_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    if (res_go && mode_q && last_q) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= btbf_pkg::StClear;
      clr_q <= '0;
      en_q <= 1'b1;
      lg_q <= 4'd6;
      p1_q <= '0;
      p2_q <= '0;
      seen_q <= '0;
      ms_q <= 1'b1;
      wr_q <= '0;
      ov_q <= 1'b0;
      hstep_q <= '0;
      k_q <= '0;
    end else begin
      st_q <= st_d;
      ms_q <= ms_d;
      ov_q <= ov_d;
      if (psel && penable && pwrite) begin
        if (paddr[2] == btbf_pkg::RegEnable) en_q <= pwdata[0];
        else lg_q <= pwdata[3:0];
      end
      if (st_q == btbf_pkg::StClear) clr_q <= clr_q + 1'b1;
      if (acc) hstep_q <= '0;
      if (st_q == btbf_pkg::StHash) hstep_q <= hstep_q + 2'd1;
      if (st_q == btbf_pkg::StHash) k_q <= '0;
      if (st_q == btbf_pkg::StRead) k_q <= k_q + 1'b1;
      if (res_go) begin
        if (!mode_q && en_q && inr_q) wr_q[blk_q] <= 1'b1;
        if (last_q) begin
          seen_q <= '0;
          p1_q <= '0;
          p2_q <= '0;
        end else begin
          p2_q <= p1_q;
          p1_q <= c_q;
          if (seen_q != 2'd2) seen_q <= seen_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      c_q <= lc;
      mode_q <= mode_i;
      last_q <= last_byte_i;
      inr_q <= lblk < btbf_pkg::LineBlkW'(btbf_pkg::NumBlocks);
      blk_q <= lblk[btbf_pkg::BlkW-1:0];
      h_q <= btbf_pkg::FnvBasis;
    end
    if (st_q == btbf_pkg::StHash) begin
      h_q <= hmul;
      if (hstep_q == 2'd2) comb_q <= hmul[63:32];
    end
    if (st_q == btbf_pkg::StProbe) begin
      addr_q <= {blk_q, bitpos[btbf_pkg::OffW+2:3]};
      bm_q <= 8'd1 << bitpos[2:0];
      rd_q <= mem[{blk_q, bitpos[btbf_pkg::OffW+2:3]}];
      comb_q <= comb_q + (h_q[31:0] | 32'd1);
    end
    if (st_q == btbf_pkg::StClear) mem[clr_q] <= 8'd0;
    else if (st_q == btbf_pkg::StRead && !mode_q) mem[addr_q] <= rd_q | bm_q;
    if (res_go && mode_q && last_q) m_q <= !en_q || !written || ms_q;
  end
endmodule
`default_nettype wire

// ----- rtl/btbf_checker.sv -----
`default_nettype none
module btbf_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic mode_i,
  input wire logic last_byte_i
);
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready after request");
  a_nores_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !mode_i && !out_valid_o |=> !out_valid_o)
    else $error("add gave result");
  a_nores_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !last_byte_i && !out_valid_o |=> !out_valid_o)
    else $error("early result");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
endmodule
bind blocked_trigram_bloom_filter_unit btbf_checker u_chk (.*);
`default_nettype wire
